/* sv/dcc_pkg.sv */
`timescale 1ns / 1ps

package dcc_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [6:0]  entry_index;
    logic [15:0] entry_count;
    logic        was_new;
    logic        dropped_full;
    logic [7:0]  distinct_total;
  } out_t;

  typedef struct packed {
    logic valid;
    logic resolved;
    logic is_new;
  } tok_ctl_t;

endpackage

/* sv/distinct_color_counter.sv */
`timescale 1ns / 1ps
// channel  | ports                   | handshake
// ---------+-------------------------+------------------------------------
// input    | start, busy, in_data    | beat taken when start && !busy
// result   | out_valid, out_data     | one-cycle strobe, no back-pressure
//
// An item walks the row of TABLE_DEPTH cells, one cell per cycle; each cell
// holds one table slot. The result is registered once the item leaves the
// last cell, and busy stays high while the beat is in the row, so a new item
// is taken only after the last one has left the row.
// Synchronous active-low reset empties the table; the receiver cannot stall.

module distinct_color_counter
  import dcc_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int COUNT_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int RW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  tok_ctl_t              ctl_s [TABLE_DEPTH+1];
  in_t                   key_s [TABLE_DEPTH+1];
  logic [RW-1:0]         rem_s [TABLE_DEPTH+1];
  logic [IW-1:0]         idx_s [TABLE_DEPTH+1];
  logic [COUNT_BITS-1:0] cnt_s [TABLE_DEPTH+1];

  logic          busy_r, busy_nxt;
  logic [RW-1:0] used_r, used_nxt;
  logic          out_valid_r;
  out_t          out_data_r, out_data_nxt;
  logic          accept;
  tok_ctl_t      last_ctl;
  logic [31:0]   idx_ext, cnt_ext, tot_ext;

  assign accept = start && !busy_r;

  assign ctl_s[0] = {accept, 2'b00};
  assign key_s[0] = in_data;
  assign rem_s[0] = used_r;
  assign idx_s[0] = '0;
  assign cnt_s[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dcc_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .COUNT_BITS  (COUNT_BITS),
      .CELL_INDEX  (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[g]),
      .key_i (key_s[g]),
      .rem_i (rem_s[g]),
      .idx_i (idx_s[g]),
      .cnt_i (cnt_s[g]),
      .ctl_o (ctl_s[g+1]),
      .key_o (key_s[g+1]),
      .rem_o (rem_s[g+1]),
      .idx_o (idx_s[g+1]),
      .cnt_o (cnt_s[g+1])
    );
  end

  always_comb begin
    last_ctl = ctl_s[TABLE_DEPTH];
    used_nxt = used_r;
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (last_ctl.valid) begin
      busy_nxt = 1'b0;
      used_nxt = used_r + RW'(last_ctl.is_new);
    end
    idx_ext = 32'(idx_s[TABLE_DEPTH]);
    cnt_ext = 32'(cnt_s[TABLE_DEPTH]);
    tot_ext = 32'(used_nxt);
    out_data_nxt.entry_index    = idx_ext[6:0];
    out_data_nxt.entry_count    = cnt_ext[15:0];
    out_data_nxt.was_new        = last_ctl.is_new;
    out_data_nxt.dropped_full   = !last_ctl.resolved;
    out_data_nxt.distinct_total = tot_ext[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      used_r      <= used_nxt;
      out_valid_r <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (last_ctl.valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/dcc_cell.sv */
`timescale 1ns / 1ps

module dcc_cell
  import dcc_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int COUNT_BITS  = 16,
  parameter int CELL_INDEX  = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tok_ctl_t                       ctl_i,
  input  in_t                            key_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] rem_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] idx_i,
  input  logic [COUNT_BITS-1:0]          cnt_i,
  output tok_ctl_t                       ctl_o,
  output in_t                            key_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] rem_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx_o,
  output logic [COUNT_BITS-1:0]          cnt_o
);

  localparam int RW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);

  in_t                   color_r, color_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  tok_ctl_t              ctl_r, ctl_nxt;
  in_t                   key_r;
  logic [RW-1:0]         rem_r, rem_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    color_nxt = color_r;
    count_nxt = count_r;
    ctl_nxt   = ctl_i;
    rem_nxt   = rem_i;
    idx_nxt   = idx_i;
    cnt_nxt   = cnt_i;
    if (ctl_i.valid && !ctl_i.resolved) begin
      if (rem_i == '0) begin
        // claim free slot
        color_nxt        = key_i;
        count_nxt        = COUNT_BITS'(1);
        ctl_nxt.resolved = 1'b1;
        ctl_nxt.is_new   = 1'b1;
        idx_nxt          = IW'(CELL_INDEX);
        cnt_nxt          = COUNT_BITS'(1);
      end else if (color_r == key_i) begin
        // hold at maximum, else advance
        count_nxt        = (&count_r) ? count_r : count_r + 1'b1;
        ctl_nxt.resolved = 1'b1;
        idx_nxt          = IW'(CELL_INDEX);
        cnt_nxt          = (&count_r) ? count_r : count_r + 1'b1;
      end else begin
        rem_nxt = rem_i - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    color_r <= color_nxt;
    count_r <= count_nxt;
    key_r   <= key_i;
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign ctl_o = ctl_r;
  assign key_o = key_r;
  assign rem_o = rem_r;
  assign idx_o = idx_r;
  assign cnt_o = cnt_r;

endmodule
